// ----- rtl/core/twa_pkg.sv -----
// twa_pkg: shared types, codes and constants for the trade aggregator
// no dependencies

package twa_pkg;

  localparam int unsigned TableEntries = 32;
  localparam int unsigned SymbolBits = 8;
  localparam int unsigned MaxResults = 32;
  localparam logic [31:0] WindowSizeReset = 32'd1000;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_WINDOW = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_LATE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // one request, decoded by the front part
  typedef struct packed {
    logic req_type;
    logic [47:0] event_time;
    logic [7:0] symbol_id;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [47:0] start;
  } job_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] status;
    logic [47:0] window_start;
    logic [7:0] window_symbol;
    logic [31:0] trade_count;
    logic [63:0] volume_sum;
    logic [31:0] price_min;
    logic [31:0] price_max;
    logic last;
    logic [31:0] late_drop_count;
    logic [5:0] open_windows;
  } result_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SCAN,
    BK_MUL,
    BK_UPD,
    BK_FSCAN,
    BK_FEMIT,
    BK_FDONE,
    BK_OUT
  } back_state_t;

endpackage

// ----- rtl/core/twa_front.sv -----
// twa_front: accepts requests and computes the window start by restoring division
// depends on twa_pkg

module twa_front (
  input  logic clk,
  input  logic rst,
  input  logic [31:0] win_size,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [47:0] event_time,
  input  logic [7:0] symbol_id,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  output logic job_valid,
  input  logic job_ready,
  output twa_pkg::job_t job
);

  twa_pkg::front_state_t state, state_next;
  twa_pkg::job_t held;
  logic [47:0] rem;
  logic [32:0] ws;
  logic [5:0] bitcnt;
  logic [48:0] rem_sh;

  assign in_ready = (state == twa_pkg::FR_IDLE);
  assign job_valid = (state == twa_pkg::FR_PUSH);
  assign rem_sh = {rem, held.event_time[bitcnt]};

  // window start is the time minus its remainder
  always_comb begin
    job = held;
    job.start = held.event_time - rem;
  end

  always_comb begin
    state_next = state;
    case (state)
      twa_pkg::FR_IDLE: if (in_valid) state_next = twa_pkg::FR_DIV;
      twa_pkg::FR_DIV: if (bitcnt == 6'd0) state_next = twa_pkg::FR_PUSH;
      twa_pkg::FR_PUSH: if (job_ready) state_next = twa_pkg::FR_IDLE;
      default: state_next = twa_pkg::FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= twa_pkg::FR_IDLE;
    else state <= state_next;
  end

  // one remainder step per cycle, msb first
  always_ff @(posedge clk) begin
    case (state)
      twa_pkg::FR_IDLE: begin
        held.req_type <= req_type;
        held.event_time <= event_time;
        held.symbol_id <= 8'(symbol_id[twa_pkg::SymbolBits-1:0]);
        held.price <= price;
        held.quantity <= quantity;
        held.start <= '0;
        ws <= {1'b0, (win_size == 32'd0) ? 32'd1 : win_size};
        rem <= '0;
        bitcnt <= 6'd47;
      end
      twa_pkg::FR_DIV: begin
        if (rem_sh >= {16'd0, ws}) begin
          rem <= 48'(rem_sh - {16'd0, ws});
        end else begin
          rem <= rem_sh[47:0];
        end
        bitcnt <= bitcnt - 6'd1;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/twa_queue.sv -----
// twa_queue: two-entry queue of decoded requests between front and back
// depends on twa_pkg

module twa_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  twa_pkg::job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output twa_pkg::job_t out_job
);

  twa_pkg::job_t slots [2];
  logic wptr, rptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slots[wptr] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (out_valid && out_ready) rptr <= ~rptr;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

endmodule

// ----- rtl/core/twa_back.sv -----
// twa_back: window table, trade update and flush ordering
// depends on twa_pkg

module twa_back #(
  parameter int unsigned TABLE_ENTRIES = twa_pkg::TableEntries
) (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  twa_pkg::job_t job,
  output logic out_valid,
  input  logic out_ready,
  output twa_pkg::result_t res
);

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

  twa_pkg::back_state_t state;
  twa_pkg::job_t cur;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [47:0] e_start [TABLE_ENTRIES];
  logic [7:0] e_sym [TABLE_ENTRIES];
  logic [31:0] e_cnt [TABLE_ENTRIES];
  logic [63:0] e_vol [TABLE_ENTRIES];
  logic [31:0] e_min [TABLE_ENTRIES];
  logic [31:0] e_max [TABLE_ENTRIES];
  logic [47:0] cutoff;
  logic [31:0] late_cnt;
  logic [CW-1:0] open_cnt;
  logic [IW:0] idx;
  logic [IW-1:0] slot, best;
  logic hit, freehit, bestok;
  logic [63:0] prod;
  logic [CW-1:0] closed, emitted, nemit;
  logic [64:0] vsum;
  logic [IW-1:0] ii;

  assign ii = idx[IW-1:0];
  assign job_ready = (state == twa_pkg::BK_IDLE);
  assign out_valid = (state == twa_pkg::BK_OUT);
  assign vsum = {1'b0, e_vol[slot]} + {1'b0, prod};
  // windows this flush sends out, capped at the result limit
  assign nemit = (32'(closed) > twa_pkg::MaxResults) ? CW'(twa_pkg::MaxResults) : closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twa_pkg::BK_IDLE;
      valid <= '0;
      cutoff <= '0;
      late_cnt <= '0;
      open_cnt <= '0;
    end else begin
      case (state)
        twa_pkg::BK_IDLE: begin
          if (job_valid) begin
            cur <= job;
            idx <= '0;
            hit <= 1'b0;
            freehit <= 1'b0;
            bestok <= 1'b0;
            emitted <= '0;
            closed <= '0;
            if (job.req_type) state <= twa_pkg::BK_FSCAN;
            else if (job.start < cutoff) begin
              late_cnt <= (late_cnt == '1) ? late_cnt : late_cnt + 32'd1;
              res <= '{kind: twa_pkg::KIND_ACK, status: twa_pkg::ST_LATE,
                       window_start: job.start, window_symbol: job.symbol_id,
                       last: 1'b1,
                       late_drop_count: (late_cnt == '1) ? late_cnt : late_cnt + 32'd1,
                       open_windows: 6'(open_cnt), default: '0};
              state <= twa_pkg::BK_OUT;
            end else state <= twa_pkg::BK_SCAN;
          end
        end
        // one entry per cycle: first match, else first free
        twa_pkg::BK_SCAN: begin
          if (valid[ii]) begin
            if (!hit && e_start[ii] == cur.start && e_sym[ii] == cur.symbol_id) begin
              hit <= 1'b1;
              slot <= ii;
            end
          end else if (!freehit) begin
            freehit <= 1'b1;
            if (!hit) slot <= ii;
          end
          if (idx == (IW+1)'(TABLE_ENTRIES - 1)) state <= twa_pkg::BK_MUL;
          idx <= idx + (IW+1)'(1);
        end
        twa_pkg::BK_MUL: begin
          prod <= {32'd0, cur.price} * {32'd0, cur.quantity};
          if (!hit && !freehit) begin
            res <= '{kind: twa_pkg::KIND_ACK, status: twa_pkg::ST_FULL,
                     window_start: cur.start, window_symbol: cur.symbol_id,
                     last: 1'b1, late_drop_count: late_cnt,
                     open_windows: 6'(open_cnt), default: '0};
            state <= twa_pkg::BK_OUT;
          end else begin
            if (!hit) begin
              valid[slot] <= 1'b1;
              open_cnt <= open_cnt + CW'(1);
              e_start[slot] <= cur.start;
              e_sym[slot] <= cur.symbol_id;
              e_cnt[slot] <= '0;
              e_vol[slot] <= '0;
              e_min[slot] <= cur.price;
              e_max[slot] <= cur.price;
            end
            state <= twa_pkg::BK_UPD;
          end
        end
        twa_pkg::BK_UPD: begin
          e_cnt[slot] <= (e_cnt[slot] == '1) ? e_cnt[slot] : e_cnt[slot] + 32'd1;
          e_vol[slot] <= vsum[64] ? '1 : vsum[63:0];
          if (cur.price < e_min[slot]) e_min[slot] <= cur.price;
          if (cur.price > e_max[slot]) e_max[slot] <= cur.price;
          res <= '{kind: twa_pkg::KIND_ACK, status: twa_pkg::ST_OK,
                   window_start: cur.start, window_symbol: cur.symbol_id,
                   trade_count: (e_cnt[slot] == '1) ? e_cnt[slot] : e_cnt[slot] + 32'd1,
                   volume_sum: vsum[64] ? '1 : vsum[63:0],
                   price_min: (cur.price < e_min[slot]) ? cur.price : e_min[slot],
                   price_max: (cur.price > e_max[slot]) ? cur.price : e_max[slot],
                   last: 1'b1, late_drop_count: late_cnt,
                   open_windows: 6'(open_cnt), default: '0};
          state <= twa_pkg::BK_OUT;
        end
        // find the oldest closed window, one entry per cycle; the first pass
        // also counts the closed windows
        twa_pkg::BK_FSCAN: begin
          if (valid[ii] && e_start[ii] < cur.start) begin
            if (emitted == '0) closed <= closed + CW'(1);
            if (!bestok || e_start[ii] < e_start[best] ||
                (e_start[ii] == e_start[best] && e_sym[ii] < e_sym[best])) begin
              best <= ii;
              bestok <= 1'b1;
            end
          end
          if (idx == (IW+1)'(TABLE_ENTRIES - 1)) begin
            state <= twa_pkg::BK_FEMIT;
          end
          idx <= idx + (IW+1)'(1);
        end
        twa_pkg::BK_FEMIT: begin
          if (bestok) begin
            res <= '{kind: twa_pkg::KIND_WINDOW, status: twa_pkg::ST_OK,
                     window_start: e_start[best], window_symbol: e_sym[best],
                     trade_count: e_cnt[best], volume_sum: e_vol[best],
                     price_min: e_min[best], price_max: e_max[best],
                     last: (emitted + CW'(1) == nemit), late_drop_count: late_cnt,
                     open_windows: 6'(open_cnt + emitted - nemit), default: '0};
            valid[best] <= 1'b0;
            open_cnt <= open_cnt - CW'(1);
            emitted <= emitted + CW'(1);
            state <= twa_pkg::BK_OUT;
          end else begin
            state <= twa_pkg::BK_FDONE;
          end
          if (cur.start > cutoff) cutoff <= cur.start;
        end
        twa_pkg::BK_FDONE: begin
          res <= '{kind: twa_pkg::KIND_EMPTY, status: twa_pkg::ST_OK,
                   window_start: cutoff, last: 1'b1, late_drop_count: late_cnt,
                   open_windows: 6'(open_cnt), default: '0};
          state <= twa_pkg::BK_OUT;
        end
        twa_pkg::BK_OUT: begin
          if (out_ready) begin
            if (res.kind == twa_pkg::KIND_WINDOW && !res.last) begin
              // more closed windows left, scan again for the next oldest
              state <= twa_pkg::BK_FSCAN;
              idx <= '0;
              bestok <= 1'b0;
            end else state <= twa_pkg::BK_IDLE;
          end
        end
        default: state <= twa_pkg::BK_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/twa_lastfix.sv -----
// twa_lastfix: one-result output register on the result channel
// depends on twa_pkg

module twa_lastfix (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  twa_pkg::result_t in_res,
  output logic out_valid,
  input  logic out_ready,
  output twa_pkg::result_t out_res
);

  logic held;
  twa_pkg::result_t hold;

  assign in_ready = !held || out_ready;
  assign out_valid = held;
  assign out_res = hold;

  always_ff @(posedge clk) begin
    if (rst) held <= 1'b0;
    else if (in_valid && in_ready) held <= 1'b1;
    else if (out_ready) held <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hold <= in_res;
  end

endmodule

// ----- rtl/core/tumbling_window_trade_aggregator.sv -----
// tumbling_window_trade_aggregator: top level
// depends on twa_pkg, twa_front, twa_queue, twa_back, twa_lastfix
// a trade goes through the restoring divide, the queue handoff, the table scan, the
// update and the output register; a flush sends the oldest closed window first and
// scans again for each further one. the front takes a new request only after its last
// one is queued; reset is synchronous, empties the table, clears cutoff and late count

module tumbling_window_trade_aggregator #(
  parameter int unsigned TABLE_ENTRIES = twa_pkg::TableEntries
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic in_valid,
  output logic in_ready,
  input  logic req_type,
  input  logic [47:0] event_time,
  input  logic [7:0] symbol_id,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] kind,
  output logic [1:0] status,
  output logic [47:0] window_start,
  output logic [7:0] window_symbol,
  output logic [31:0] trade_count,
  output logic [63:0] volume_sum,
  output logic [31:0] price_min,
  output logic [31:0] price_max,
  output logic last,
  output logic [31:0] late_drop_count,
  output logic [5:0] open_windows
);

  logic [31:0] win_size;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  twa_pkg::job_t fjob, bjob;
  logic b_valid, b_ready;
  twa_pkg::result_t bres, ores;

  always_ff @(posedge clk) begin
    if (rst) win_size <= twa_pkg::WindowSizeReset;
    else if (cfg_we) win_size <= cfg_wdata;
  end

  twa_front u_front (
    .clk, .rst, .win_size, .in_valid, .in_ready, .req_type, .event_time,
    .symbol_id, .price, .quantity,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fjob)
  );

  twa_queue u_queue (
    .clk, .rst, .in_valid(fj_valid), .in_ready(fj_ready), .in_job(fjob),
    .out_valid(bj_valid), .out_ready(bj_ready), .out_job(bjob)
  );

  twa_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst, .job_valid(bj_valid), .job_ready(bj_ready), .job(bjob),
    .out_valid(b_valid), .out_ready(b_ready), .res(bres)
  );

  twa_lastfix u_lastfix (
    .clk, .rst, .in_valid(b_valid), .in_ready(b_ready), .in_res(bres),
    .out_valid, .out_ready, .out_res(ores)
  );

  assign kind = ores.kind;
  assign status = ores.status;
  assign window_start = ores.window_start;
  assign window_symbol = ores.window_symbol;
  assign trade_count = ores.trade_count;
  assign volume_sum = ores.volume_sum;
  assign price_min = ores.price_min;
  assign price_max = ores.price_max;
  assign last = ores.last;
  assign late_drop_count = ores.late_drop_count;
  assign open_windows = ores.open_windows;

endmodule
